// ===== design/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared widths, types and helper functions of the step barrier crossing check.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int COORD_BITS = 24;
	localparam int PROB_BITS  = 16;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [CROSS_W-1:0]    cross_t;
	typedef logic        [PROB_BITS-1:0]  prob_t;

	typedef enum logic [1:0] {
		TURN_COL = 2'd0,
		TURN_CW  = 2'd1,
		TURN_CCW = 2'd2
	} turn_t;

	// One captured input word: a = step start, b = step end, c/d = barrier ends.
	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
		coord_t cx;
		coord_t cy;
		coord_t dx;
		coord_t dy;
		prob_t  chance;
		prob_t  draw;
		logic   last;
	} item_t;

	// Coordinate differences used by the four cross products.
	typedef struct packed {
		diff_t      dyab;
		diff_t      dxab;
		diff_t      dxbc;
		diff_t      dybc;
		diff_t      dxbd;
		diff_t      dybd;
		diff_t      dycd;
		diff_t      dxcd;
		diff_t      dxda;
		diff_t      dyda;
		diff_t      dxdb;
		diff_t      dydb;
		logic [3:0] on_box;
		logic       prob_hit;
		logic       last;
	} diff_word_t;

	// Both products of each orientation test.
	typedef struct packed {
		prod_t      l1;
		prod_t      r1;
		prod_t      l2;
		prod_t      r2;
		prod_t      l3;
		prod_t      r3;
		prod_t      l4;
		prod_t      r4;
		logic [3:0] on_box;
		logic       prob_hit;
		logic       last;
	} prod_word_t;

	typedef struct packed {
		logic hit;
		logic last;
	} scan_t;

	// True when point q lies inside the bounding box spanned by p and r.
	function automatic logic in_box(input coord_t px, input coord_t py,
	                                input coord_t qx, input coord_t qy,
	                                input coord_t rx, input coord_t ry);
		logic inx;
		logic iny;
		inx = (qx <= px || qx <= rx) && (qx >= px || qx >= rx);
		iny = (qy <= py || qy <= ry) && (qy >= py || qy >= ry);
		return inx && iny;
	endfunction

	function automatic turn_t turn_of(input cross_t v);
		turn_t t;
		if (v == '0) begin
			t = TURN_COL;
		end else if (v[CROSS_W-1]) begin
			t = TURN_CCW;
		end else begin
			t = TURN_CW;
		end
		return t;
	endfunction

endpackage

// ===== design/sbc_prep.sv =====
// ----------------------------------------------------------------------------
// sbc_prep
// Second stage: coordinate differences, on-segment box tests and the
// probability compare.
// ----------------------------------------------------------------------------
module sbc_prep (
	input  logic                clk,
	input  logic                en,
	input  sbc_pkg::item_t      item,
	output sbc_pkg::diff_word_t diff_s2
);

	sbc_pkg::diff_word_t diff_d;

	always_comb begin
		diff_d.dyab = sbc_pkg::diff_t'(item.by) - sbc_pkg::diff_t'(item.ay);
		diff_d.dxab = sbc_pkg::diff_t'(item.bx) - sbc_pkg::diff_t'(item.ax);
		diff_d.dxbc = sbc_pkg::diff_t'(item.cx) - sbc_pkg::diff_t'(item.bx);
		diff_d.dybc = sbc_pkg::diff_t'(item.cy) - sbc_pkg::diff_t'(item.by);
		diff_d.dxbd = sbc_pkg::diff_t'(item.dx) - sbc_pkg::diff_t'(item.bx);
		diff_d.dybd = sbc_pkg::diff_t'(item.dy) - sbc_pkg::diff_t'(item.by);
		diff_d.dycd = sbc_pkg::diff_t'(item.dy) - sbc_pkg::diff_t'(item.cy);
		diff_d.dxcd = sbc_pkg::diff_t'(item.dx) - sbc_pkg::diff_t'(item.cx);
		diff_d.dxda = sbc_pkg::diff_t'(item.ax) - sbc_pkg::diff_t'(item.dx);
		diff_d.dyda = sbc_pkg::diff_t'(item.ay) - sbc_pkg::diff_t'(item.dy);
		diff_d.dxdb = sbc_pkg::diff_t'(item.bx) - sbc_pkg::diff_t'(item.dx);
		diff_d.dydb = sbc_pkg::diff_t'(item.by) - sbc_pkg::diff_t'(item.dy);
		// Bit i pairs with orientation test i+1 (t1..t4) later on.
		diff_d.on_box[0] = sbc_pkg::in_box(item.ax, item.ay, item.cx, item.cy,
		                                   item.bx, item.by);
		diff_d.on_box[1] = sbc_pkg::in_box(item.ax, item.ay, item.dx, item.dy,
		                                   item.bx, item.by);
		diff_d.on_box[2] = sbc_pkg::in_box(item.cx, item.cy, item.ax, item.ay,
		                                   item.dx, item.dy);
		diff_d.on_box[3] = sbc_pkg::in_box(item.cx, item.cy, item.bx, item.by,
		                                   item.dx, item.dy);
		diff_d.prob_hit  = item.draw > item.chance;
		diff_d.last      = item.last;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2 <= diff_d;
		end
	end

endmodule

// ===== design/sbc_prod.sv =====
// ----------------------------------------------------------------------------
// sbc_prod
// Third stage: the eight exact products of the four orientation tests.
// ----------------------------------------------------------------------------
module sbc_prod (
	input  logic                clk,
	input  logic                en,
	input  sbc_pkg::diff_word_t diff_s2,
	output sbc_pkg::prod_word_t prod_s3
);

	sbc_pkg::prod_word_t prod_d;

	always_comb begin
		prod_d.l1 = diff_s2.dyab * diff_s2.dxbc;
		prod_d.r1 = diff_s2.dxab * diff_s2.dybc;
		prod_d.l2 = diff_s2.dyab * diff_s2.dxbd;
		prod_d.r2 = diff_s2.dxab * diff_s2.dybd;
		prod_d.l3 = diff_s2.dycd * diff_s2.dxda;
		prod_d.r3 = diff_s2.dxcd * diff_s2.dyda;
		prod_d.l4 = diff_s2.dycd * diff_s2.dxdb;
		prod_d.r4 = diff_s2.dxcd * diff_s2.dydb;
		prod_d.on_box   = diff_s2.on_box;
		prod_d.prob_hit = diff_s2.prob_hit;
		prod_d.last     = diff_s2.last;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_d;
		end
	end

endmodule

// ===== design/sbc_orient.sv =====
// ----------------------------------------------------------------------------
// sbc_orient
// Fourth stage: orientation codes, the segment intersection decision and
// the blocking decision for one barrier.
// ----------------------------------------------------------------------------
module sbc_orient (
	input  logic                clk,
	input  logic                en,
	input  sbc_pkg::prod_word_t prod_s3,
	output sbc_pkg::scan_t      scan_s4
);

	sbc_pkg::turn_t t1;
	sbc_pkg::turn_t t2;
	sbc_pkg::turn_t t3;
	sbc_pkg::turn_t t4;
	logic           meet;
	sbc_pkg::scan_t scan_d;

	always_comb begin
		t1 = sbc_pkg::turn_of(sbc_pkg::cross_t'(prod_s3.l1) - sbc_pkg::cross_t'(prod_s3.r1));
		t2 = sbc_pkg::turn_of(sbc_pkg::cross_t'(prod_s3.l2) - sbc_pkg::cross_t'(prod_s3.r2));
		t3 = sbc_pkg::turn_of(sbc_pkg::cross_t'(prod_s3.l3) - sbc_pkg::cross_t'(prod_s3.r3));
		t4 = sbc_pkg::turn_of(sbc_pkg::cross_t'(prod_s3.l4) - sbc_pkg::cross_t'(prod_s3.r4));
		// General crossing, or a collinear endpoint lying on the other segment.
		meet = (t1 != t2 && t3 != t4)
		    || (t1 == sbc_pkg::TURN_COL && prod_s3.on_box[0])
		    || (t2 == sbc_pkg::TURN_COL && prod_s3.on_box[1])
		    || (t3 == sbc_pkg::TURN_COL && prod_s3.on_box[2])
		    || (t4 == sbc_pkg::TURN_COL && prod_s3.on_box[3]);
		scan_d.hit  = meet && prod_s3.prob_hit;
		scan_d.last = prod_s3.last;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scan_s4 <= scan_d;
		end
	end

endmodule

// ===== design/step_barrier_crossing_check.sv =====
// ----------------------------------------------------------------------------
// step_barrier_crossing_check
// Streams barrier segments against a movement step and reports whether the
// step is blocked.
// ----------------------------------------------------------------------------
// One barrier word is accepted per clock while the input is not stalled. Each
// word passes an input register and three compute stages (differences,
// products, orientation decision), and its result then reaches the output
// register. The product stage holds one 25 by 25 bit multiply layer. The
// first blocking barrier of a scan yields a result of 1; later words of that
// scan still flow through but yield nothing. A scan with no blocking barrier
// yields 0 on its last word. The input is stalled only when the pipeline is
// full and the output register is held.
module step_barrier_crossing_check (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  sbc_pkg::coord_t        step_start_x,
	input  sbc_pkg::coord_t        step_start_y,
	input  sbc_pkg::coord_t        step_end_x,
	input  sbc_pkg::coord_t        step_end_y,
	input  sbc_pkg::coord_t        fence_start_x,
	input  sbc_pkg::coord_t        fence_start_y,
	input  sbc_pkg::coord_t        fence_end_x,
	input  sbc_pkg::coord_t        fence_end_y,
	input  sbc_pkg::prob_t         pass_chance,
	input  sbc_pkg::prob_t         uniform_draw,
	input  logic                   scan_last,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   blocked
);

	sbc_pkg::item_t      item_s1;
	sbc_pkg::diff_word_t diff_s2;
	sbc_pkg::prod_word_t prod_s3;
	sbc_pkg::scan_t      scan_s4;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic verdict_q;
	logic res_valid_q;
	logic blocked_q;

	logic out_free;
	logic emit;
	logic adv4;
	logic ready1;
	logic ready2;
	logic ready3;
	logic ready4;

	always_comb begin
		out_free = !res_valid_q || !result_stall;
		emit     = valid_s4 && !verdict_q && (scan_s4.hit || scan_s4.last);
		// A word that yields nothing leaves the last stage without waiting.
		adv4     = valid_s4 && (!emit || out_free);
		ready4   = !valid_s4 || adv4;
		ready3   = !valid_s3 || ready4;
		ready2   = !valid_s2 || ready3;
		ready1   = !valid_s1 || ready2;
	end

	assign item_stall   = !ready1;
	assign result_valid = res_valid_q;
	assign blocked      = blocked_q;

	always_ff @(posedge clk) begin
		if (ready1) begin
			item_s1.ax     <= step_start_x;
			item_s1.ay     <= step_start_y;
			item_s1.bx     <= step_end_x;
			item_s1.by     <= step_end_y;
			item_s1.cx     <= fence_start_x;
			item_s1.cy     <= fence_start_y;
			item_s1.dx     <= fence_end_x;
			item_s1.dy     <= fence_end_y;
			item_s1.chance <= pass_chance;
			item_s1.draw   <= uniform_draw;
			item_s1.last   <= scan_last;
		end
	end

	sbc_prep u_prep (
		.clk     (clk),
		.en      (ready2),
		.item    (item_s1),
		.diff_s2 (diff_s2)
	);

	sbc_prod u_prod (
		.clk     (clk),
		.en      (ready3),
		.diff_s2 (diff_s2),
		.prod_s3 (prod_s3)
	);

	sbc_orient u_orient (
		.clk     (clk),
		.en      (ready4),
		.prod_s3 (prod_s3),
		.scan_s4 (scan_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			verdict_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ready1) begin
				valid_s1 <= item_valid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
			if (ready4) begin
				valid_s4 <= valid_s3;
			end
			if (adv4) begin
				verdict_q <= scan_s4.last ? 1'b0 : (verdict_q | scan_s4.hit);
			end
			if (adv4 && emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && emit) begin
			blocked_q <= scan_s4.hit;
		end
	end

endmodule
